// ===== rtl/distance_histogram_chi2_scorer_unit_defines.svh =====
// Assertion macros shared by the scorer RTL.
`ifndef DISTANCE_HISTOGRAM_CHI2_SCORER_UNIT_DEFINES_SVH
`define DISTANCE_HISTOGRAM_CHI2_SCORER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define DHCS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dhcs assertion failed");
// antecedent implies consequent in the next cycle
`define DHCS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dhcs assertion failed");
`else
`define DHCS_ASSERT_IMP(label, clk, rst, ante, cons)
`define DHCS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/dhcs_pkg.sv =====
package dhcs_pkg;

  localparam int DHCS_NUM_BINS = 1024;

  // config port
  localparam int CFG_AW = 5;
  localparam logic [2:0] CFG_RANGE_MIN     = 3'd0;
  localparam logic [2:0] CFG_RANGE_MAX     = 3'd1;
  localparam logic [2:0] CFG_INV_BIN_WIDTH = 3'd2;
  localparam logic [2:0] CFG_FIT_FIRST     = 3'd3;
  localparam logic [2:0] CFG_FIT_LAST      = 3'd4;
  localparam logic [2:0] CFG_INV_SIGMA_SQ  = 3'd5;
  localparam logic [2:0] CFG_INV_SAMPLES   = 3'd6;

  // request codes
  localparam logic [2:0] REQ_LOAD_REF  = 3'd0;
  localparam logic [2:0] REQ_LOAD_NORM = 3'd1;
  localparam logic [2:0] REQ_ADD       = 3'd2;
  localparam logic [2:0] REQ_SUB       = 3'd3;
  localparam logic [2:0] REQ_EVAL      = 3'd4;
  localparam logic [2:0] REQ_ACCEPT    = 3'd5;
  localparam logic [2:0] REQ_REVERT    = 3'd6;
  localparam logic [2:0] REQ_NONE      = 3'd7;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SKIP  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_UNDER = 2'd3;

  localparam logic [47:0] Q48_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [23:0] distance;
    logic [9:0]  bin_index;
    logic [31:0] table_value;
  } req_t;

  typedef struct packed {
    logic [47:0] chi2_value;
    logic [1:0]  status;
    logic [9:0]  bin_hit;
  } rsp_t;

endpackage

// ===== rtl/dhcs_term.sv =====
// Per-bin chi2 term: ((count*isc*norm>>16 - ref)^2>>16 * isig)>>16, saturated.
// Eight register stages, one bin per cycle.
module dhcs_term import dhcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic [31:0] count,
  input  logic [23:0] ref_val,
  input  logic [31:0] norm,
  input  logic [16:0] inv_samples,
  input  logic [31:0] inv_sigma_sq,
  output logic        term_vld,
  output logic [47:0] term
);

  logic [7:0]  vld;
  logic [48:0] h1;
  logic [23:0] ref1, ref2, ref3;
  logic [31:0] norm1;
  logic [63:0] plo2;
  logic [48:0] phi2;
  logic [47:0] pcf3, diff4;
  logic [47:0] aa5, ab5, bb5;
  logic [47:0] sq6;
  logic [55:0] mlo7, mhi7;
  logic [47:0] term8;

  logic [80:0] pcf_full;
  logic [95:0] sq_full;
  logic [79:0] term_full;

  assign pcf_full  = {phi2, 32'd0} + 81'(plo2);
  assign sq_full   = {aa5, 48'd0} + (96'(ab5) << 25) + 96'(bb5);
  assign term_full = {mhi7, 24'd0} + 80'(mlo7);

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:0], in_vld};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    h1    <= 49'(count) * 49'(inv_samples);
    ref1  <= ref_val;
    norm1 <= norm;
    plo2  <= 64'(h1[31:0]) * 64'(norm1);
    phi2  <= 49'(h1[48:32]) * 49'(norm1);
    ref2  <= ref1;
    pcf3  <= (pcf_full[80:64] != '0) ? Q48_MAX : pcf_full[63:16];
    ref3  <= ref2;
    diff4 <= (pcf3 >= 48'(ref3)) ? pcf3 - 48'(ref3) : 48'(ref3) - pcf3;
    aa5   <= 48'(diff4[47:24]) * 48'(diff4[47:24]);
    ab5   <= 48'(diff4[47:24]) * 48'(diff4[23:0]);
    bb5   <= 48'(diff4[23:0]) * 48'(diff4[23:0]);
    sq6   <= (sq_full[95:64] != '0) ? Q48_MAX : sq_full[63:16];
    mlo7  <= 56'(sq6[23:0]) * 56'(inv_sigma_sq);
    mhi7  <= 56'(sq6[47:24]) * 56'(inv_sigma_sq);
    term8 <= (term_full[79:64] != '0) ? Q48_MAX : term_full[63:16];
  end

  assign term_vld = vld[7];
  assign term     = term8;

endmodule

// ===== rtl/dhcs_div.sv =====
// Restoring divider, one quotient bit per cycle.
module dhcs_div #(
  parameter int DW = 59,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int NW = $clog2(DW + 1);

  logic [VW:0]   rem;
  logic [VW:0]   shifted;
  logic [VW-1:0] dvs;
  logic [NW-1:0] steps;
  logic          busy;
  logic          ge;

  assign shifted = {rem[VW-1:0], quotient[DW-1]};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        steps    <= NW'(DW);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= ge ? shifted - {1'b0, dvs} : shifted;
        quotient <= {quotient[DW-2:0], ge};
        steps    <= steps - NW'(1);
        if (steps == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/distance_histogram_chi2_scorer_unit.sv =====
// Channel  Direction  Payload  Handshake
// req      in         req_t    req_valid / req_stall
// rsp      out        rsp_t    rsp_valid / rsp_stall
// cfg      in         APB      psel / penable / pwrite / pready
//
// One request at a time; the next is taken while a result waits in the output register.
// Load: decode and table write, then result. Add/subtract: bin multiply, count read, write back.
// Evaluate: one bin per cycle through the term pipeline, then a bit-serial mean divider.
// Accept/revert: one count copied per cycle through the memory port.
// After reset a clearing pass over every bin zeroes both histograms; no request taken.
`include "distance_histogram_chi2_scorer_unit_defines.svh"
module distance_histogram_chi2_scorer_unit import dhcs_pkg::*; #(
  parameter int NUM_BINS = DHCS_NUM_BINS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IW = $clog2(NUM_BINS);
  localparam int CW = IW + 1;
  localparam int SW = 48 + CW;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_MULT   = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_RD     = 4'd5;
  localparam logic [3:0] S_WR     = 4'd6;
  localparam logic [3:0] S_EVAL   = 4'd7;
  localparam logic [3:0] S_EWAIT  = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_COPY   = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  // configuration registers
  logic [23:0] range_min, range_max, inv_bin_width;
  logic [9:0]  fit_first, fit_last;
  logic [31:0] inv_sigma_sq;
  logic [16:0] inv_samples;

  // control and payload registers
  logic [3:0]    state;
  req_t          req_r;
  logic [1:0]    status_r;
  logic [9:0]    hit_r;
  logic [23:0]   off_r;
  logic [47:0]   prod_r;
  logic [IW-1:0] bin_r;
  logic [CW-1:0] cnt;
  logic [SW-1:0] sum;
  logic [CW-1:0] tcount;
  logic          ev_rd;
  logic          copy_wen;
  logic [IW-1:0] copy_waddr;
  logic [47:0]   chi_commit, chi_trial;

  // memories
  logic [23:0] ref_mem   [NUM_BINS];
  logic [31:0] norm_mem  [NUM_BINS];
  logic [31:0] trial_mem [NUM_BINS];
  logic [31:0] comm_mem  [NUM_BINS];
  logic [23:0] ref_rdata;
  logic [31:0] norm_rdata, trial_rdata, comm_rdata;

  logic          trial_we, comm_we, ref_we, norm_we;
  logic [IW-1:0] trial_wa, comm_wa, trial_ra;
  logic [31:0]   trial_wd, comm_wd;

  logic          cfg_wr, accept_req, fin_load, idx_ok, skip, div_start, div_done;
  logic          term_vld;
  logic [47:0]   term;
  logic [SW-1:0] quotient;
  logic [IW-1:0] first_c, last_c, eff_last;
  logic [CW-1:0] nbins;
  logic [15:0]   bin16;
  logic [31:0]   cur;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign req_stall  = (state != S_IDLE);
  assign accept_req = req_valid && !req_stall;
  assign fin_load   = (state == S_FIN) && (!rsp_valid || !rsp_stall);

  // fit window, clamped to the table
  assign first_c  = (32'(fit_first) > 32'(NUM_BINS - 1)) ? IW'(NUM_BINS - 1) : IW'(fit_first);
  assign last_c   = (32'(fit_last) > 32'(NUM_BINS - 1)) ? IW'(NUM_BINS - 1) : IW'(fit_last);
  assign eff_last = (last_c < first_c) ? first_c : last_c;
  assign nbins    = CW'(eff_last) - CW'(first_c) + CW'(1);

  assign idx_ok = 32'(req_r.bin_index) < 32'(NUM_BINS);
  assign skip   = (req_r.distance < range_min) || (req_r.distance >= range_max);
  assign bin16  = prod_r[47:32];
  assign cur    = trial_rdata;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      range_min     <= 24'd0;
      range_max     <= 24'hFF_FFFF;
      inv_bin_width <= 24'd65536;
      fit_first     <= 10'd0;
      fit_last      <= 10'd1023;
      inv_sigma_sq  <= 32'd65536;
      inv_samples   <= 17'd65536;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        CFG_RANGE_MIN:     range_min     <= pwdata[23:0];
        CFG_RANGE_MAX:     range_max     <= pwdata[23:0];
        CFG_INV_BIN_WIDTH: inv_bin_width <= pwdata[23:0];
        CFG_FIT_FIRST:     fit_first     <= pwdata[9:0];
        CFG_FIT_LAST:      fit_last      <= pwdata[9:0];
        CFG_INV_SIGMA_SQ:  inv_sigma_sq  <= pwdata;
        CFG_INV_SAMPLES:   inv_samples   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    unique case (paddr[4:2])
      CFG_RANGE_MIN:     prdata = 32'(range_min);
      CFG_RANGE_MAX:     prdata = 32'(range_max);
      CFG_INV_BIN_WIDTH: prdata = 32'(inv_bin_width);
      CFG_FIT_FIRST:     prdata = 32'(fit_first);
      CFG_FIT_LAST:      prdata = 32'(fit_last);
      CFG_INV_SIGMA_SQ:  prdata = inv_sigma_sq;
      CFG_INV_SAMPLES:   prdata = 32'(inv_samples);
      default:           prdata = 32'd0;
    endcase
  end

  // memory write and read selection
  always_comb begin
    ref_we   = (state == S_DECODE) && (req_r.req_type == REQ_LOAD_REF) && idx_ok;
    norm_we  = (state == S_DECODE) && (req_r.req_type == REQ_LOAD_NORM) && idx_ok;
    trial_ra = (state == S_RD) ? bin_r : cnt[IW-1:0];
    trial_we = 1'b0;
    trial_wa = cnt[IW-1:0];
    trial_wd = 32'd0;
    comm_we  = 1'b0;
    comm_wa  = cnt[IW-1:0];
    comm_wd  = 32'd0;
    priority if (state == S_CLEAR) begin
      trial_we = 1'b1;
      comm_we  = 1'b1;
    end else if (state == S_WR) begin
      trial_wa = bin_r;
      if (req_r.req_type == REQ_ADD) begin
        trial_we = 1'b1;
        trial_wd = (cur == COUNT_MAX) ? cur : cur + 32'd1;
      end else begin
        trial_we = (cur != 32'd0);
        trial_wd = cur - 32'd1;
      end
    end else if (copy_wen) begin
      if (req_r.req_type == REQ_REVERT) begin
        trial_we = 1'b1;
        trial_wa = copy_waddr;
        trial_wd = comm_rdata;
      end else begin
        comm_we = 1'b1;
        comm_wa = copy_waddr;
        comm_wd = trial_rdata;
      end
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[IW'(req_r.bin_index)] <= req_r.table_value[23:0];
    end
    if (norm_we) begin
      norm_mem[IW'(req_r.bin_index)] <= req_r.table_value;
    end
    ref_rdata  <= ref_mem[cnt[IW-1:0]];
    norm_rdata <= norm_mem[cnt[IW-1:0]];
  end

  // histogram memories
  always_ff @(posedge clk) begin
    if (trial_we) begin
      trial_mem[trial_wa] <= trial_wd;
    end
    if (comm_we) begin
      comm_mem[comm_wa] <= comm_wd;
    end
    trial_rdata <= trial_mem[trial_ra];
    comm_rdata  <= comm_mem[cnt[IW-1:0]];
  end

  assign div_start = (state == S_EWAIT) && (tcount == nbins);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      rsp_valid  <= 1'b0;
      ev_rd      <= 1'b0;
      copy_wen   <= 1'b0;
      chi_commit <= 48'd0;
      chi_trial  <= 48'd0;
    end else begin
      ev_rd      <= (state == S_EVAL);
      copy_wen   <= (state == S_COPY);
      copy_waddr <= cnt[IW-1:0];
      if (rsp_valid && !rsp_stall && !fin_load) begin
        rsp_valid <= 1'b0;
      end
      if (term_vld) begin
        sum    <= sum + SW'(term);
        tcount <= tcount + CW'(1);
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(NUM_BINS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept_req) begin
            req_r <= req;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          status_r <= STAT_OK;
          hit_r    <= 10'd0;
          off_r    <= req_r.distance - range_min;
          cnt      <= '0;
          unique case (req_r.req_type)
            REQ_LOAD_REF, REQ_LOAD_NORM: begin
              if (!idx_ok) begin
                status_r <= STAT_RANGE;
              end
              state <= S_FIN;
            end
            REQ_ADD, REQ_SUB: begin
              if (skip) begin
                status_r <= STAT_SKIP;
                state    <= S_FIN;
              end else begin
                state <= S_MULT;
              end
            end
            REQ_EVAL: begin
              cnt    <= CW'(first_c);
              sum    <= '0;
              tcount <= '0;
              state  <= S_EVAL;
            end
            REQ_ACCEPT, REQ_REVERT: state <= S_COPY;
            default: state <= S_FIN;
          endcase
        end
        S_MULT: begin
          prod_r <= 48'(off_r) * 48'(inv_bin_width);
          state  <= S_CHECK;
        end
        S_CHECK: begin
          hit_r <= bin16[9:0];
          bin_r <= IW'(bin16);
          if (32'(bin16) >= 32'(NUM_BINS)) begin
            status_r <= STAT_RANGE;
            state    <= S_FIN;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (req_r.req_type == REQ_SUB && cur == 32'd0) begin
            status_r <= STAT_UNDER;
          end
          state <= S_FIN;
        end
        S_EVAL: begin
          cnt <= cnt + CW'(1);
          if (cnt[IW-1:0] == eff_last) begin
            state <= S_EWAIT;
          end
        end
        S_EWAIT: begin
          if (div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            chi_trial <= quotient[47:0];
            state     <= S_FIN;
          end
        end
        S_COPY: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(NUM_BINS - 1)) begin
            if (req_r.req_type == REQ_ACCEPT) begin
              chi_commit <= chi_trial;
            end else begin
              chi_trial <= chi_commit;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            rsp_valid      <= 1'b1;
            rsp.chi2_value <= (req_r.req_type == REQ_EVAL) ? chi_trial : chi_commit;
            rsp.status     <= status_r;
            rsp.bin_hit    <= hit_r;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  dhcs_term u_term (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (ev_rd),
    .count        (trial_rdata),
    .ref_val      (ref_rdata),
    .norm         (norm_rdata),
    .inv_samples  (inv_samples),
    .inv_sigma_sq (inv_sigma_sq),
    .term_vld     (term_vld),
    .term         (term)
  );

  dhcs_div #(
    .DW (SW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (nbins),
    .done     (div_done),
    .quotient (quotient)
  );

  // checks
  `DHCS_ASSERT_IMP(a_term_count, clk, rst, term_vld, tcount < nbins)
  `DHCS_ASSERT_NXT(a_rsp_load, clk, rst, fin_load, rsp_valid)
  `DHCS_ASSERT_IMP(a_copy_state, clk, rst, copy_wen, state == S_COPY || state == S_FIN)

endmodule
